### design/wps_pkg.sv
// ----------------------------------------------------------------------------
// wps_pkg
// Shared constants and types for the waveform peak segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package wps_pkg;

  localparam int THR_BITS = 16;
  localparam int STEP_SHIFT = 4;
  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 16'd48;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic emit_a;
    logic emit_b;
  } wps_push_t;

endpackage

`default_nettype wire

### design/wps_sample_if.sv
// ----------------------------------------------------------------------------
// wps_sample_if
// Sample channel: valid/ready handshake with one waveform sample per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface wps_sample_if #(
  parameter int ADC_BITS  = 12,
  parameter int TIME_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [ADC_BITS-1:0]  sample_value;
  logic [TIME_BITS-1:0] sample_time;
  logic                 last_sample;

  modport source (output valid, output sample_value, output sample_time,
                  output last_sample, input ready);
  modport sink (input valid, input sample_value, input sample_time,
                input last_sample, output ready);
endinterface

`default_nettype wire

### design/wps_peak_if.sv
// ----------------------------------------------------------------------------
// wps_peak_if
// Peak channel: valid/ready handshake with one closed segment per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface wps_peak_if #(
  parameter int ADC_BITS  = 12,
  parameter int TIME_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] peak_time;
  logic [ADC_BITS-1:0]  peak_height;
  logic                 last_peak;

  modport source (output valid, output peak_time, output peak_height,
                  output last_peak, input ready);
  modport sink (input valid, input peak_time, input peak_height,
                input last_peak, output ready);
endinterface

`default_nettype wire

### design/wps_core.sv
// ----------------------------------------------------------------------------
// wps_core
// Input register, segment state and hysteresis compare; emits up to two
// closed segments per sample into the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_core
  import wps_pkg::*;
#(
  parameter int ADC_BITS  = 12,
  parameter int TIME_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [THR_BITS-1:0]  cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ADC_BITS-1:0]  in_value,
  input  wire logic [TIME_BITS-1:0] in_time,
  input  wire logic                 in_last,
  input  wire logic                 has_room,
  output wps_push_t                 push,
  output logic [TIME_BITS-1:0]      a_time,
  output logic [ADC_BITS-1:0]       a_height,
  output logic                      a_last,
  output logic [TIME_BITS-1:0]      b_time,
  output logic [ADC_BITS-1:0]       b_height
);

  localparam int CmpW = ADC_BITS + STEP_SHIFT + THR_BITS;

  logic [THR_BITS-1:0]  step_threshold;

  logic                 q_valid;
  logic [ADC_BITS-1:0]  q_value;
  logic [TIME_BITS-1:0] q_time;
  logic                 q_last;

  logic [ADC_BITS-1:0]  segment_max, segment_max_next;
  logic [TIME_BITS-1:0] segment_max_time, segment_max_time_next;
  logic [ADC_BITS-1:0]  previous_value, previous_value_next;
  logic                 falling_seen, falling_seen_next;
  logic                 segment_open, segment_open_next;

  logic                 fire;
  logic [ADC_BITS-1:0]  diff_dn, diff_up;
  logic [CmpW-1:0]      thr_ext, dn_ext, up_ext;
  logic                 drop, rise, brk;

  assign fire = q_valid && has_room;
  assign in_ready = !q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      step_threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_value <= in_value;
      q_time  <= in_time;
      q_last  <= in_last;
    end
  end

  // hysteresis compare: 16 * |step| > threshold
  always_comb begin
    diff_dn = previous_value - q_value;
    diff_up = q_value - previous_value;
    thr_ext = {{(ADC_BITS + STEP_SHIFT){1'b0}}, step_threshold};
    dn_ext  = {{THR_BITS{1'b0}}, diff_dn, {STEP_SHIFT{1'b0}}};
    up_ext  = {{THR_BITS{1'b0}}, diff_up, {STEP_SHIFT{1'b0}}};
    drop    = (previous_value > q_value) && (dn_ext > thr_ext);
    rise    = (q_value > previous_value) && (up_ext > thr_ext);
    brk     = segment_open && falling_seen && rise;
  end

  always_comb begin
    segment_max_next      = segment_max;
    segment_max_time_next = segment_max_time;
    previous_value_next   = previous_value;
    falling_seen_next     = falling_seen;
    segment_open_next     = segment_open;
    if (!segment_open || brk) begin
      segment_max_next      = q_value;
      segment_max_time_next = q_time;
      previous_value_next   = q_value;
      falling_seen_next     = 1'b0;
      segment_open_next     = 1'b1;
    end else begin
      falling_seen_next   = falling_seen || drop;
      previous_value_next = q_value;
      if (q_value > segment_max) begin
        segment_max_next      = q_value;
        segment_max_time_next = q_time;
      end
    end
    if (q_last) begin
      segment_open_next = 1'b0;
      falling_seen_next = 1'b0;
    end
  end

  always_comb begin
    push.emit_a = fire && (brk || q_last);
    push.emit_b = fire && brk && q_last;
    if (brk) begin
      a_time   = segment_max_time;
      a_height = segment_max;
      a_last   = 1'b0;
    end else begin
      a_time   = segment_max_time_next;
      a_height = segment_max_next;
      a_last   = 1'b1;
    end
    b_time   = q_time;
    b_height = q_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_max      <= '0;
      segment_max_time <= '0;
      previous_value   <= '0;
      falling_seen     <= 1'b0;
      segment_open     <= 1'b0;
    end else if (fire) begin
      segment_max      <= segment_max_next;
      segment_max_time <= segment_max_time_next;
      previous_value   <= previous_value_next;
      falling_seen     <= falling_seen_next;
      segment_open     <= segment_open_next;
    end
  end

endmodule

`default_nettype wire

### design/wps_outq.sv
// ----------------------------------------------------------------------------
// wps_outq
// Small result queue: takes up to two peak words per cycle, hands out one when peak is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_outq
  import wps_pkg::*;
#(
  parameter int ADC_BITS  = 12,
  parameter int TIME_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire wps_push_t            push,
  input  wire logic [TIME_BITS-1:0] a_time,
  input  wire logic [ADC_BITS-1:0]  a_height,
  input  wire logic                 a_last,
  input  wire logic [TIME_BITS-1:0] b_time,
  input  wire logic [ADC_BITS-1:0]  b_height,
  output logic                      has_room,
  wps_peak_if.source                peak
);

  localparam int EntW = TIME_BITS + ADC_BITS + 1;

  logic [EntW-1:0]     entries [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OQ_CNT_W-1:0] count;
  logic                pop;
  logic [OQ_CNT_W-1:0] push_n;
  logic [EntW-1:0]     rd_entry;

  assign pop = peak.valid && peak.ready;
  assign push_n = OQ_CNT_W'(push.emit_a) + OQ_CNT_W'(push.emit_b);
  assign has_room = count <= OQ_CNT_W'(OQ_DEPTH - 2);

  assign rd_entry = entries[rd_ptr];
  assign peak.valid = count != '0;
  assign peak.peak_time = rd_entry[EntW-1 -: TIME_BITS];
  assign peak.peak_height = rd_entry[ADC_BITS:1];
  assign peak.last_peak = rd_entry[0];

  always_ff @(posedge clk) begin
    if (push.emit_a) begin
      entries[wr_ptr] <= {a_time, a_height, a_last};
    end
    if (push.emit_b) begin
      entries[wr_ptr + OQ_PTR_W'(1)] <= {b_time, b_height, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[OQ_PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      count <= count + push_n - OQ_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

### design/waveform_peak_segmenter.sv
// ----------------------------------------------------------------------------
// waveform_peak_segmenter
// Splits a digitizer waveform into peak segments with step hysteresis.
//
//   channel   dir  word
//   sample    in   sample_value, sample_time, last_sample
//   peak      out  peak_time, peak_height, last_peak
//   cfg       in   cfg_wr_en, cfg_wr_data (step_threshold)
//
// one sample per cycle while the queue has room; a result passes through
// the input register, then the result queue
// a last sample that breaks a segment yields two words
// peak stalls fill a four-word queue; a held sample waits, and sample ready
// drops, while fewer than two words are free
// rst clears segment state and queue and resets threshold to 48
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_peak_segmenter
  import wps_pkg::*;
#(
  parameter int ADC_BITS  = 12,
  parameter int TIME_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [THR_BITS-1:0] cfg_wr_data,
  wps_sample_if.sink               sample,
  wps_peak_if.source               peak
);

  wps_push_t            push;
  logic                 has_room;
  logic                 in_ready;
  logic [TIME_BITS-1:0] a_time, b_time;
  logic [ADC_BITS-1:0]  a_height, b_height;
  logic                 a_last;

  assign sample.ready = in_ready;

  wps_core #(
    .ADC_BITS  (ADC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (sample.valid),
    .in_ready    (in_ready),
    .in_value    (sample.sample_value),
    .in_time     (sample.sample_time),
    .in_last     (sample.last_sample),
    .has_room    (has_room),
    .push        (push),
    .a_time      (a_time),
    .a_height    (a_height),
    .a_last      (a_last),
    .b_time      (b_time),
    .b_height    (b_height)
  );

  wps_outq #(
    .ADC_BITS  (ADC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .a_time   (a_time),
    .a_height (a_height),
    .a_last   (a_last),
    .b_time   (b_time),
    .b_height (b_height),
    .has_room (has_room),
    .peak     (peak)
  );

endmodule

`default_nettype wire
